>>> hw/rtl/rett_pkg.sv
package rett_pkg;

  localparam int unsigned SlotsDefault = 16;

  typedef enum logic [3:0] {
    CmdTick       = 4'd0,
    CmdAdd        = 4'd1,
    CmdRemoveType = 4'd2,
    CmdRemoveAll  = 4'd3,
    CmdRemoveSlot = 4'd4,
    CmdSetPeriod  = 4'd5,
    CmdSetLeft    = 4'd6,
    CmdSetBoth    = 4'd7,
    CmdHas        = 4'd8,
    CmdGetPeriod  = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFull     = 2'd1,
    StatusSlotFree = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StWalk,
    StFire,
    StDone
  } state_e;

  localparam logic KindFired = 1'b0;
  localparam logic KindDone  = 1'b1;

  // Row of the entry table, kept in one memory word.
  typedef struct packed {
    logic [15:0] etype;
    logic [31:0] period;
    logic [31:0] left;
    logic [15:0] repeats;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

>>> hw/rtl/rett_ram.sv
module rett_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/repeating_event_timer_table_unit.sv
// Sequence: after a command transfers, the sequencer addresses slot 0 (StRead), then
//   walks the slots on the entry memory one row a cycle (StWalk), except that a
//   firing entry also passes through StFire and waits there while the output stalls;
//   StDone registers the completion report. A new command waits until idle again.
// Reset: valid bits cleared, sequencer idle, no report pending; entry memory
//   is not cleared.
module repeating_event_timer_table_unit #(
  parameter int unsigned SLOTS = rett_pkg::SlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [3:0]  cmd_i,
  input  logic [15:0] event_type_i,
  input  logic [31:0] time_value_i,
  input  logic [15:0] repeat_count_i,
  input  logic [3:0]  slot_select_i,
  input  logic        force_time_left_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        item_kind_o,
  output logic [3:0]  slot_o,
  output logic [15:0] fired_type_o,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [31:0] period_read_o,
  output logic        last_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  rett_pkg::state_e state_q, state_d;

  // Latched command.
  logic [3:0]  cmd_q;
  logic [15:0] type_q;
  logic [31:0] tval_q;
  logic [15:0] reps_q;
  logic [3:0]  sel_q;
  logic        force_q;

  logic [SLOTS-1:0] valid_q, valid_d;
  logic [CntW-1:0]  idx_q, idx_d;

  // Result bookkeeping.
  logic [1:0]  status_q, status_d;
  logic        found_q, found_d;
  logic        got_q, got_d;
  logic [31:0] per_q, per_d;
  logic [3:0]  aslot_q, aslot_d;

  // Output register.
  logic        ovalid_q, ovalid_d;
  logic        okind_q, okind_d;
  logic [3:0]  oslot_q, oslot_d;
  logic [15:0] otype_q, otype_d;
  logic [1:0]  ostat_q, ostat_d;
  logic        ofound_q, ofound_d;
  logic [31:0] oper_q, oper_d;

  // Memory port.
  logic                    we;
  logic [IdxW-1:0]         waddr, raddr;
  rett_pkg::entry_t        wdata, rdata;
  logic [rett_pkg::EntryW-1:0] rdata_raw;

  rett_ram #(.Width(rett_pkg::EntryW), .Depth(SLOTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );
  assign rdata = rett_pkg::entry_t'(rdata_raw);

  logic [IdxW-1:0] cur;      // slot whose row sits on the read data
  logic            hit;
  logic            fires;
  logic [15:0]     reps_dec;
  logic            out_free;
  logic            sel_ok;

  assign cur      = idx_q[IdxW-1:0];
  assign hit      = valid_q[cur] && (rdata.etype == type_q);
  assign fires    = rdata.left <= tval_q;
  assign reps_dec = rdata.repeats - 16'd1;
  assign out_free = !ovalid_q || !stall_i;
  assign sel_ok   = ({28'd0, sel_q} < 32'(SLOTS)) && valid_q[IdxW'(sel_q)];

  assign stall_o = (state_q != rett_pkg::StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rett_pkg::StIdle;
      valid_q  <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      cmd_q   <= cmd_i;
      type_q  <= event_type_i;
      tval_q  <= time_value_i;
      reps_q  <= repeat_count_i;
      sel_q   <= slot_select_i;
      force_q <= force_time_left_i;
    end
    status_q <= status_d;
    found_q  <= found_d;
    got_q    <= got_d;
    per_q    <= per_d;
    aslot_q  <= aslot_d;
    okind_q  <= okind_d;
    oslot_q  <= oslot_d;
    otype_q  <= otype_d;
    ostat_q  <= ostat_d;
    ofound_q <= ofound_d;
    oper_q   <= oper_d;
  end

  always_comb begin
    state_d  = state_q;
    valid_d  = valid_q;
    idx_d    = idx_q;
    status_d = status_q;
    found_d  = found_q;
    got_d    = got_q;
    per_d    = per_q;
    aslot_d  = aslot_q;
    ovalid_d = ovalid_q && stall_i;
    okind_d  = okind_q;
    oslot_d  = oslot_q;
    otype_d  = otype_q;
    ostat_d  = ostat_q;
    ofound_d = ofound_q;
    oper_d   = oper_q;
    we       = 1'b0;
    waddr    = cur;
    wdata    = rdata;
    raddr    = idx_q[IdxW-1:0];

    case (state_q)
      rett_pkg::StIdle: begin
        if (valid_i) begin
          idx_d    = '0;
          status_d = rett_pkg::StatusOk;
          found_d  = 1'b0;
          got_d    = 1'b0;
          per_d    = '0;
          aslot_d  = '0;
          state_d  = rett_pkg::StRead;
        end
      end
      // Address slot idx on the memory; data shows next cycle.
      rett_pkg::StRead: begin
        state_d = rett_pkg::StWalk;
      end
      rett_pkg::StWalk: begin
        // One slot per cycle; a firing entry waits in StFire for the output.
        state_d = rett_pkg::StWalk;
        idx_d   = idx_q + CntW'(1);
        raddr   = IdxW'(idx_q + CntW'(1));
        case (rett_pkg::cmd_e'(cmd_q))
          rett_pkg::CmdTick: begin
            if (valid_q[cur]) begin
              if (fires) begin
                state_d = rett_pkg::StFire;
                idx_d   = idx_q;
                raddr   = cur;
              end else begin
                we         = 1'b1;
                wdata.left = rdata.left - tval_q;
              end
            end
          end
          rett_pkg::CmdAdd: begin
            if (!valid_q[cur] && !got_d) begin
              got_d         = 1'b1;
              valid_d[cur]  = 1'b1;
              aslot_d       = 4'(cur);
              we            = 1'b1;
              wdata.etype   = type_q;
              wdata.period  = tval_q;
              wdata.left    = tval_q;
              wdata.repeats = reps_q;
            end
          end
          rett_pkg::CmdRemoveType: if (hit) valid_d[cur] = 1'b0;
          rett_pkg::CmdRemoveAll:  valid_d[cur] = 1'b0;
          rett_pkg::CmdSetPeriod: begin
            if (hit) begin
              we           = 1'b1;
              wdata.period = tval_q;
            end
          end
          rett_pkg::CmdSetLeft: begin
            if (hit) begin
              we         = 1'b1;
              wdata.left = (force_q || tval_q <= rdata.period) ? tval_q : rdata.period;
            end
          end
          rett_pkg::CmdSetBoth: begin
            if (hit) begin
              we           = 1'b1;
              wdata.period = tval_q;
              wdata.left   = tval_q;
            end
          end
          rett_pkg::CmdHas: if (hit) found_d = 1'b1;
          rett_pkg::CmdGetPeriod: begin
            if (hit && !got_q) begin
              got_d = 1'b1;
              per_d = rdata.period;
            end
          end
          default: ;
        endcase
        if (state_d == rett_pkg::StWalk && idx_q == CntW'(SLOTS - 1)) begin
          state_d = rett_pkg::StDone;
        end
      end
      // Hand out a fired report and reload or free the entry.
      // Hold the row on the read data until the report can go out.
      rett_pkg::StFire: begin
        raddr = cur;
        if (out_free) begin
          raddr    = IdxW'(idx_q + CntW'(1));
          ovalid_d = 1'b1;
          okind_d  = rett_pkg::KindFired;
          oslot_d  = 4'(cur);
          otype_d  = rdata.etype;
          ostat_d  = rett_pkg::StatusOk;
          ofound_d = 1'b0;
          oper_d   = '0;
          we       = 1'b1;
          wdata.left = rdata.period;
          if (rdata.repeats != 16'd0) begin
            wdata.repeats = reps_dec;
            if (reps_dec == 16'd0) valid_d[cur] = 1'b0;
          end
          idx_d   = idx_q + CntW'(1);
          state_d = (idx_q == CntW'(SLOTS - 1)) ? rett_pkg::StDone : rett_pkg::StWalk;
        end
      end
      rett_pkg::StDone: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = rett_pkg::KindDone;
          oslot_d  = '0;
          otype_d  = '0;
          ostat_d  = rett_pkg::StatusOk;
          ofound_d = found_q;
          oper_d   = per_q;
          state_d  = rett_pkg::StIdle;
          case (rett_pkg::cmd_e'(cmd_q))
            rett_pkg::CmdAdd: begin
              if (got_q) oslot_d = aslot_q;
              else       ostat_d = rett_pkg::StatusFull;
            end
            rett_pkg::CmdRemoveSlot: begin
              if (sel_ok) valid_d[IdxW'(sel_q)] = 1'b0;
              else        ostat_d = rett_pkg::StatusSlotFree;
            end
            default: ;
          endcase
        end
      end
      default: state_d = rett_pkg::StIdle;
    endcase
  end

  assign valid_o       = ovalid_q;
  assign item_kind_o   = okind_q;
  assign slot_o        = oslot_q;
  assign fired_type_o  = otype_q;
  assign status_o      = ostat_q;
  assign found_o       = ofound_q;
  assign period_read_o = oper_q;
  assign last_o        = okind_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rett_pkg::StIdle) |-> !stall_o)
    else $error("stall while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rett_pkg::StDone && out_free) |=> (state_q == rett_pkg::StIdle && ovalid_q))
    else $error("completion report missing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rett_pkg::StFire && out_free) |=> (ovalid_q && !okind_q))
    else $error("fired report missing");

endmodule

>>> bench/repeating_event_timer_table_unit_test.sv
module repeating_event_timer_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned StallLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [3:0]  cmd_i = '0;
  logic [15:0] event_type_i = '0;
  logic [31:0] time_value_i = '0;
  logic [15:0] repeat_count_i = '0;
  logic [3:0]  slot_select_i = '0;
  logic        force_time_left_i = 1'b0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic        item_kind_o;
  logic [3:0]  slot_o;
  logic [15:0] fired_type_o;
  logic [1:0]  status_o;
  logic        found_o;
  logic [31:0] period_read_o;
  logic        last_o;

  // One report as the block presents it.
  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [15:0] ftype;
    logic [1:0]  status;
    logic        found;
    logic [31:0] period;
    logic        last;
  } report_t;

  repeating_event_timer_table_unit #(.SLOTS(NumSlots)) dut (.*);

  always #1 clk_i = ~clk_i;

  // Shadow copy of the event table.
  logic        shadow_valid  [NumSlots];
  logic [15:0] shadow_type   [NumSlots];
  logic [31:0] shadow_period [NumSlots];
  logic [31:0] shadow_left   [NumSlots];
  logic [15:0] shadow_repeats[NumSlots];

  report_t pending_reports[$];
  int      error_count = 0;
  int      reports_seen = 0;
  int      fired_seen = 0;
  int      commands_sent = 0;
  int      idle_cycles = 0;
  bit      bursts_on = 1'b1;
  bit      sink_idle = 1'b0;

  // Small type pool so that removes, sets and queries actually hit entries.
  function automatic logic [15:0] pick_type();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 8) return 16'(r * 16'h1111);
    return 16'($urandom);
  endfunction

  function automatic report_t make_report(logic kind, logic [3:0] slot, logic [15:0] ftype,
                                          logic [1:0] status, logic found,
                                          logic [31:0] period, logic last);
    report_t r;
    r.kind = kind; r.slot = slot; r.ftype = ftype; r.status = status;
    r.found = found; r.period = period; r.last = last;
    return r;
  endfunction

  // Append one expected report at the tail of the queue.
  function automatic void queue_report(report_t r);
    pending_reports = {pending_reports, r};
  endfunction

  // Apply one command to the shadow table and queue the reports it causes.
  task automatic predict_command(logic [3:0] cmd, logic [15:0] etype, logic [31:0] tval,
                                 logic [15:0] reps, logic [3:0] sel, logic force_left);
    logic [3:0]  slot_taken;
    logic [1:0]  status;
    logic        found;
    logic [31:0] period;
    slot_taken = '0; status = rett_pkg::StatusOk; found = 1'b0; period = '0;
    case (cmd)
      rett_pkg::CmdTick: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (!shadow_valid[i]) continue;
          if (shadow_left[i] <= tval) begin
            queue_report(make_report(rett_pkg::KindFired, 4'(i), shadow_type[i],
                                     rett_pkg::StatusOk, 1'b0, '0, 1'b0));
            if (shadow_repeats[i] != 0) begin
              shadow_repeats[i]--;
              if (shadow_repeats[i] == 0) begin
                shadow_valid[i] = 1'b0;
                continue;
              end
            end
            shadow_left[i] = shadow_period[i];
          end else begin
            shadow_left[i] -= tval;
          end
        end
      end
      rett_pkg::CmdAdd: begin
        status = rett_pkg::StatusFull;
        for (int i = 0; i < NumSlots; i++) begin
          if (!shadow_valid[i]) begin
            shadow_valid[i] = 1'b1; shadow_type[i] = etype;
            shadow_period[i] = tval; shadow_left[i] = tval;
            shadow_repeats[i] = reps; slot_taken = 4'(i); status = rett_pkg::StatusOk;
            break;
          end
        end
      end
      rett_pkg::CmdRemoveType:
        for (int i = 0; i < NumSlots; i++)
          if (shadow_valid[i] && shadow_type[i] == etype) shadow_valid[i] = 1'b0;
      rett_pkg::CmdRemoveAll:
        for (int i = 0; i < NumSlots; i++) shadow_valid[i] = 1'b0;
      rett_pkg::CmdRemoveSlot: begin
        if (shadow_valid[sel]) shadow_valid[sel] = 1'b0;
        else status = rett_pkg::StatusSlotFree;
      end
      rett_pkg::CmdSetPeriod, rett_pkg::CmdSetLeft, rett_pkg::CmdSetBoth: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (!shadow_valid[i] || shadow_type[i] != etype) continue;
          if (cmd == rett_pkg::CmdSetPeriod) begin
            shadow_period[i] = tval;
          end else if (cmd == rett_pkg::CmdSetLeft) begin
            // Unforced write clamps the time left to the period.
            shadow_left[i] = (force_left || tval <= shadow_period[i]) ? tval : shadow_period[i];
          end else begin
            shadow_period[i] = tval; shadow_left[i] = tval;
          end
        end
      end
      rett_pkg::CmdHas:
        for (int i = 0; i < NumSlots; i++)
          if (shadow_valid[i] && shadow_type[i] == etype) found = 1'b1;
      rett_pkg::CmdGetPeriod:
        for (int i = 0; i < NumSlots; i++)
          if (shadow_valid[i] && shadow_type[i] == etype) begin
            period = shadow_period[i];
            break;
          end
      default: ;
    endcase
    queue_report(make_report(rett_pkg::KindDone, slot_taken, '0, status, found, period,
                             1'b1));
  endtask

  // Send one command: sometimes a random gap first, then hold until the transfer happens.
  // Valid stays high after a transfer; release_input drops it, and the next call only for a gap.
  task automatic send_command(logic [3:0] cmd, logic [15:0] etype, logic [31:0] tval,
                              logic [15:0] reps, logic [3:0] sel, logic force_left);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    valid_i           <= 1'b1;
    cmd_i             <= cmd;
    event_type_i      <= etype;
    time_value_i      <= tval;
    repeat_count_i    <= reps;
    slot_select_i     <= sel;
    force_time_left_i <= force_left;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    predict_command(cmd, etype, tval, reps, sel, force_left);
    commands_sent++;
  endtask

  task automatic release_input();
    valid_i <= 1'b0;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  // Check every report that transfers.
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && valid_o && !stall_i) begin
      reports_seen++;
      if (!item_kind_o) fired_seen++;
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected report kind", 32'(item_kind_o), 32'd0);
      end else begin
        want = pending_reports.pop_front();
        if (item_kind_o !== want.kind)
          report_mismatch("item_kind", 32'(item_kind_o), 32'(want.kind));
        if (slot_o !== want.slot) report_mismatch("slot", 32'(slot_o), 32'(want.slot));
        if (fired_type_o !== want.ftype)
          report_mismatch("fired_type", 32'(fired_type_o), 32'(want.ftype));
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (found_o !== want.found)
          report_mismatch("found", 32'(found_o), 32'(want.found));
        if (period_read_o !== want.period)
          report_mismatch("period_read", period_read_o, want.period);
        if (last_o !== want.last) report_mismatch("last", 32'(last_o), 32'(want.last));
      end
    end
  end

  // Receiver stall: random bursts while enabled, otherwise always ready.
  always @(posedge clk_i) begin
    int unsigned burst;
    if (bursts_on && !sink_idle && $urandom_range(0, 5) == 0) begin
      sink_idle = 1'b1;
      burst = $urandom_range(1, 10);
      stall_i <= 1'b1;
      repeat (burst) @(posedge clk_i);
      stall_i <= 1'b0;
      sink_idle = 1'b0;
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", StallLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_table_ops();
    send_command(rett_pkg::CmdRemoveSlot, '0, '0, '0, 4'd15, 1'b0);       // free slot
    send_command(rett_pkg::CmdAdd, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'd0, 1'b1);
    send_command(rett_pkg::CmdAdd, 16'h0000, 32'd0, 16'd0, 4'd0, 1'b0);   // repeats forever
    send_command(rett_pkg::CmdAdd, 16'h1111, 32'd5, 16'd1, 4'd0, 1'b0);
    send_command(rett_pkg::CmdHas, 16'h1111, '0, '0, '0, 1'b0);
    send_command(rett_pkg::CmdHas, 16'h4242, '0, '0, '0, 1'b0);
    send_command(rett_pkg::CmdGetPeriod, 16'hFFFF, '0, '0, '0, 1'b0);
    send_command(rett_pkg::CmdGetPeriod, 16'h4242, '0, '0, '0, 1'b0);    // no match
    send_command(rett_pkg::CmdSetLeft, 16'h1111, 32'd100, '0, '0, 1'b0); // clamped to period
    send_command(rett_pkg::CmdSetLeft, 16'h1111, 32'd100, '0, '0, 1'b1); // forced
    send_command(rett_pkg::CmdSetPeriod, 16'h1111, 32'd7, '0, '0, 1'b0);
    send_command(rett_pkg::CmdSetBoth, 16'h0000, 32'd3, '0, '0, 1'b0);
    send_command(rett_pkg::CmdTick, '0, 32'd4, '0, '0, 1'b0);
    send_command(rett_pkg::CmdTick, '0, 32'hFFFF_FFFF, '0, '0, 1'b0);    // everything fires
    send_command(4'd10, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 1'b1);
    send_command(4'd15, '0, '0, '0, '0, 1'b0);
    send_command(rett_pkg::CmdRemoveType, 16'h0000, '0, '0, '0, 1'b0);
    send_command(rett_pkg::CmdRemoveSlot, '0, '0, '0, 4'd0, 1'b0);
    send_command(rett_pkg::CmdRemoveAll, '0, '0, '0, '0, 1'b0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < NumSlots + 1; i++)
      send_command(rett_pkg::CmdAdd, 16'(i), 32'd1, 16'd2, '0, 1'b0);  // last one is refused
    send_command(rett_pkg::CmdTick, '0, 32'd1, '0, '0, 1'b0);            // sixteen fired reports
    send_command(rett_pkg::CmdGetPeriod, 16'd3, '0, '0, '0, 1'b0);
    send_command(rett_pkg::CmdRemoveAll, '0, '0, '0, '0, 1'b0);
  endtask

  task automatic test_random_mix(int count);
    logic [3:0]  cmd;
    logic [31:0] tval;
    int unsigned r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30) cmd = rett_pkg::CmdTick;
      else if (r < 55) cmd = rett_pkg::CmdAdd;
      else if (r < 97)
        cmd = 4'($urandom_range(rett_pkg::CmdRemoveType, rett_pkg::CmdGetPeriod));
      else cmd = 4'($urandom_range(10, 15));
      // Mostly small times so events fire; sometimes full range.
      tval = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 40));
      send_command(cmd, pick_type(), tval,
                   ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4)),
                   4'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NumSlots; i++) shadow_valid[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_table_ops();
    test_full_table();
    test_random_mix(320);
    // Close out at full rate: no gaps, no stalls.
    bursts_on = 1'b0;
    test_random_mix(60);
    release_input();
    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("covered %0d commands, %0d reports checked, %0d of them fired events",
             commands_sent, reports_seen, fired_seen);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d reports missing", error_count, pending_reports.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/rett_pkg.sv
hw/rtl/rett_ram.sv
hw/rtl/repeating_event_timer_table_unit.sv
bench/repeating_event_timer_table_unit_test.sv
